// ===== design/mcc_pkg.sv =====
// Package for the multichannel convolution engine: sizes, operation codes and types.
// No dependencies.
package mcc_pkg;

  localparam int MaxImageDim  = 32;
  localparam int MaxChannels  = 8;
  localparam int MaxFilterDim = 8;
  localparam int MaxFilters   = 8;
  localparam int DataWidth    = 16;
  localparam int SumWidth     = 48;

  typedef enum logic [1:0] {
    OP_LOAD_IMAGE  = 2'd0,
    OP_LOAD_WEIGHT = 2'd1,
    OP_LOAD_BIAS   = 2'd2,
    OP_COMPUTE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_IMAGE_ROWS  = 3'd0,
    REG_IMAGE_COLS  = 3'd1,
    REG_CHANNELS    = 3'd2,
    REG_FILTER_ROWS = 3'd3,
    REG_FILTER_COLS = 3'd4,
    REG_NUM_FILTERS = 3'd5,
    REG_STRIDE      = 3'd6,
    REG_PADDING     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_BIAS,
    ST_OUT
  } state_t;

  // Geometry after clamping, as the compute sequencer sees it.
  typedef struct packed {
    logic [8:0] img_rows;
    logic [8:0] img_cols;
    logic [6:0] chans;
    logic [4:0] flt_rows;
    logic [4:0] flt_cols;
    logic [6:0] filters;
    logic [3:0] stride;
    logic [2:0] padding;
  } geom_t;

endpackage

// ===== design/mcc_ram.sv =====
// Generic single-port write, single-port read RAM with registered read data.
// No dependencies.
module mcc_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mcc_regs.sv =====
// Configuration register file with APB-style access and clamped geometry output.
// Depends on mcc_pkg.
module mcc_regs #(
  parameter int MAX_IMAGE_DIM  = mcc_pkg::MaxImageDim,
  parameter int MAX_CHANNELS   = mcc_pkg::MaxChannels,
  parameter int MAX_FILTER_DIM = mcc_pkg::MaxFilterDim,
  parameter int MAX_FILTERS    = mcc_pkg::MaxFilters
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output mcc_pkg::geom_t geom
);
  import mcc_pkg::*;

  logic [5:0] img_rows_r, img_cols_r;
  logic [3:0] chans_r, flt_rows_r, flt_cols_r, filters_r, stride_r;
  logic [2:0] padding_r;
  reg_idx_t   idx;

  assign idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_rows_r <= 6'd28;
      img_cols_r <= 6'd28;
      chans_r    <= 4'd1;
      flt_rows_r <= 4'd3;
      flt_cols_r <= 4'd3;
      filters_r  <= 4'd1;
      stride_r   <= 4'd1;
      padding_r  <= 3'd0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_IMAGE_ROWS:  img_rows_r <= pwdata[5:0];
        REG_IMAGE_COLS:  img_cols_r <= pwdata[5:0];
        REG_CHANNELS:    chans_r    <= pwdata[3:0];
        REG_FILTER_ROWS: flt_rows_r <= pwdata[3:0];
        REG_FILTER_COLS: flt_cols_r <= pwdata[3:0];
        REG_NUM_FILTERS: filters_r  <= pwdata[3:0];
        REG_STRIDE:      stride_r   <= pwdata[3:0];
        REG_PADDING:     padding_r  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IMAGE_ROWS:  prdata = {26'd0, img_rows_r};
      REG_IMAGE_COLS:  prdata = {26'd0, img_cols_r};
      REG_CHANNELS:    prdata = {28'd0, chans_r};
      REG_FILTER_ROWS: prdata = {28'd0, flt_rows_r};
      REG_FILTER_COLS: prdata = {28'd0, flt_cols_r};
      REG_NUM_FILTERS: prdata = {28'd0, filters_r};
      REG_STRIDE:      prdata = {28'd0, stride_r};
      REG_PADDING:     prdata = {29'd0, padding_r};
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    geom.img_rows = (32'(img_rows_r) > MAX_IMAGE_DIM) ? 9'(MAX_IMAGE_DIM) : 9'(img_rows_r);
    geom.img_cols = (32'(img_cols_r) > MAX_IMAGE_DIM) ? 9'(MAX_IMAGE_DIM) : 9'(img_cols_r);
    geom.chans    = (32'(chans_r) > MAX_CHANNELS) ? 7'(MAX_CHANNELS) : 7'(chans_r);
    geom.flt_rows = (32'(flt_rows_r) > MAX_FILTER_DIM) ? 5'(MAX_FILTER_DIM) : 5'(flt_rows_r);
    geom.flt_cols = (32'(flt_cols_r) > MAX_FILTER_DIM) ? 5'(MAX_FILTER_DIM) : 5'(flt_cols_r);
    geom.filters  = (32'(filters_r) > MAX_FILTERS) ? 7'(MAX_FILTERS) : 7'(filters_r);
    geom.stride   = (stride_r == 4'd0) ? 4'd1 : stride_r;
    geom.padding  = padding_r;
  end

endmodule

// ===== design/multichannel_conv2d_engine.sv =====
// Top level of the multichannel convolution engine: stores, tap sequencer, MAC.
// Depends on mcc_pkg, mcc_ram and mcc_regs.
//
//  channel  direction  ports                         handshake
//  in       in         in_operation .. in_value      in_valid / in_stall
//  out      out        out_filter_index_res .. status out_valid / out_stall
//  cfg      in         psel penable pwrite paddr ... pready tied high
//
// A compute request walks every channel and filter tap, one tap per cycle
// through the image and weight memories (an error goes straight to the result
// register, a compute with no taps skips the walk).
// The result register holds while out_stall is high; a new request is taken
// once the previous result has left that register. Reset is synchronous and
// clears control state only; memory contents are undefined until loaded.
module multichannel_conv2d_engine #(
  parameter int MAX_IMAGE_DIM  = mcc_pkg::MaxImageDim,
  parameter int MAX_CHANNELS   = mcc_pkg::MaxChannels,
  parameter int MAX_FILTER_DIM = mcc_pkg::MaxFilterDim,
  parameter int MAX_FILTERS    = mcc_pkg::MaxFilters
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   in_operation,
  input  logic [2:0]   in_filter_index,
  input  logic [2:0]   in_channel,
  input  logic [4:0]   in_row,
  input  logic [4:0]   in_col,
  input  logic [15:0]  in_value,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [2:0]   out_filter_index_res,
  output logic [4:0]   out_out_row,
  output logic [4:0]   out_out_col,
  output logic [47:0]  out_sum,
  output logic         out_status,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import mcc_pkg::*;

  localparam int DimW  = $clog2(MAX_IMAGE_DIM);
  localparam int ChW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FdW   = (MAX_FILTER_DIM > 1) ? $clog2(MAX_FILTER_DIM) : 1;
  localparam int FW    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int ImgD  = MAX_CHANNELS * MAX_IMAGE_DIM * MAX_IMAGE_DIM;
  localparam int WgtD  = MAX_FILTERS * MAX_CHANNELS * MAX_FILTER_DIM * MAX_FILTER_DIM;
  localparam int ImgAW = $clog2(ImgD);
  localparam int WgtAW = (WgtD > 1) ? $clog2(WgtD) : 1;
  localparam int BiasAW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;

  geom_t geom;
  assign pready = 1'b1;

  mcc_regs #(
    .MAX_IMAGE_DIM(MAX_IMAGE_DIM), .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_FILTER_DIM(MAX_FILTER_DIM), .MAX_FILTERS(MAX_FILTERS)
  ) u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .geom
  );

  state_t state_r, state_nxt;
  logic   accept;
  logic   out_valid_r;
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign accept   = in_valid && !in_stall;

  // Load decode. Out-of-range coordinates are dropped.
  logic img_we, wgt_we, bias_we;
  logic [ImgAW-1:0]  img_waddr;
  logic [WgtAW-1:0]  wgt_waddr;
  logic [BiasAW-1:0] bias_waddr;
  always_comb begin
    img_we  = accept && in_operation == OP_LOAD_IMAGE &&
              32'(in_channel) < MAX_CHANNELS && 32'(in_row) < MAX_IMAGE_DIM &&
              32'(in_col) < MAX_IMAGE_DIM;
    wgt_we  = accept && in_operation == OP_LOAD_WEIGHT &&
              32'(in_filter_index) < MAX_FILTERS && 32'(in_channel) < MAX_CHANNELS &&
              32'(in_row) < MAX_FILTER_DIM && 32'(in_col) < MAX_FILTER_DIM;
    bias_we = accept && in_operation == OP_LOAD_BIAS &&
              32'(in_filter_index) < MAX_FILTERS;
    img_waddr  = ImgAW'((32'(in_channel) * MAX_IMAGE_DIM + 32'(in_row)) * MAX_IMAGE_DIM
                 + 32'(in_col));
    wgt_waddr  = WgtAW'(((32'(in_filter_index) * MAX_CHANNELS + 32'(in_channel))
                 * MAX_FILTER_DIM + 32'(in_row)) * MAX_FILTER_DIM + 32'(in_col));
    bias_waddr = BiasAW'(in_filter_index);
  end

  // Tap walk counters.
  logic [2:0]   f_r;
  logic [4:0]   orow_r, ocol_r;
  logic [ChW-1:0] d_r;
  logic [FdW:0] a_r, b_r;
  logic [9:0]   ybase_r, xbase_r;
  logic         status_r;

  logic signed [10:0] y, x;
  logic         tap_ok;
  logic [ImgAW-1:0] img_raddr;
  logic [WgtAW-1:0] wgt_raddr;
  logic last_b, last_a, last_d;

  always_comb begin
    y = signed'({1'b0, ybase_r}) + signed'(11'(a_r)) - signed'(11'(geom.padding));
    x = signed'({1'b0, xbase_r}) + signed'(11'(b_r)) - signed'(11'(geom.padding));
    tap_ok = (y >= 0) && (y < signed'(11'(geom.img_rows))) &&
             (x >= 0) && (x < signed'(11'(geom.img_cols))) &&
             (a_r < geom.flt_rows) && (b_r < geom.flt_cols) &&
             (7'(d_r) < geom.chans);
    img_raddr = ImgAW'((32'(d_r) * MAX_IMAGE_DIM + 32'(y[DimW-1:0])) * MAX_IMAGE_DIM
                + 32'(x[DimW-1:0]));
    wgt_raddr = WgtAW'(((32'(f_r) * MAX_CHANNELS + 32'(d_r)) * MAX_FILTER_DIM
                + 32'(a_r[FdW-1:0])) * MAX_FILTER_DIM + 32'(b_r[FdW-1:0]));
    last_b = (b_r + 1'b1 >= (FdW+1)'(geom.flt_cols));
    last_a = (a_r + 1'b1 >= (FdW+1)'(geom.flt_rows));
    last_d = (7'(d_r) + 7'd1 >= geom.chans);
  end

  logic [DataWidth-1:0] img_rd, wgt_rd, bias_rd;
  mcc_ram #(.Width(DataWidth), .Depth(ImgD)) u_img (
    .clk, .we(img_we), .waddr(img_waddr), .wdata(in_value),
    .raddr(img_raddr), .rdata(img_rd));
  mcc_ram #(.Width(DataWidth), .Depth(WgtD)) u_wgt (
    .clk, .we(wgt_we), .waddr(wgt_waddr), .wdata(in_value),
    .raddr(wgt_raddr), .rdata(wgt_rd));
  mcc_ram #(.Width(DataWidth), .Depth(MAX_FILTERS)) u_bias (
    .clk, .we(bias_we), .waddr(bias_waddr), .wdata(in_value),
    .raddr(BiasAW'(f_r)), .rdata(bias_rd));

  // Filter index and result size check: (img + 2*pad - flt) / stride + 1 > pos, i.e.
  // pos*stride + flt <= img + 2*pad.
  logic err;
  always_comb begin
    err = (7'(in_filter_index) >= geom.filters) ||
          (10'(in_row) * 10'(geom.stride) + 10'(geom.flt_rows) >
           10'(geom.img_rows) + 10'({geom.padding, 1'b0})) ||
          (10'(in_col) * 10'(geom.stride) + 10'(geom.flt_cols) >
           10'(geom.img_cols) + 10'({geom.padding, 1'b0}));
  end

  logic        v1_r;         // high while the registered read data holds a valid tap
  logic        p_ok_r;
  logic signed [31:0] prod_r;
  logic        prod_v_r;
  logic signed [SumWidth-1:0] acc_r;
  logic walk_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      prod_v_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      v1_r     <= (state_r == ST_WALK) && tap_ok;
      prod_v_r <= v1_r;
      if (state_r == ST_OUT) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    p_ok_r <= v1_r;
    prod_r <= signed'(img_rd) * signed'(wgt_rd);
    if (accept) begin
      f_r      <= in_filter_index;
      orow_r   <= in_row;
      ocol_r   <= in_col;
      ybase_r  <= 10'(in_row) * 10'(geom.stride);
      xbase_r  <= 10'(in_col) * 10'(geom.stride);
      status_r <= err;
      d_r <= '0; a_r <= '0; b_r <= '0;
      acc_r <= '0;
    end else begin
      if (state_r == ST_WALK) begin
        if (!last_b) b_r <= b_r + 1'b1;
        else begin
          b_r <= '0;
          if (!last_a) a_r <= a_r + 1'b1;
          else begin
            a_r <= '0;
            d_r <= d_r + 1'b1;
          end
        end
      end
      if (prod_v_r && p_ok_r) acc_r <= acc_r + SumWidth'(prod_r);
      if (state_r == ST_BIAS) acc_r <= acc_r + SumWidth'(signed'(bias_rd));
    end
    if (state_r == ST_OUT) begin
      out_filter_index_res <= f_r;
      out_out_row          <= orow_r;
      out_out_col          <= ocol_r;
      out_status           <= status_r;
      out_sum              <= status_r ? '0 : acc_r;
    end
  end

  assign walk_done = last_b && last_a && last_d;
  logic [1:0] drain_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_DRAIN) drain_r <= drain_r + 2'd1;
    else drain_r <= 2'd0;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_operation == OP_COMPUTE) begin
          // A compute with no taps still passes the drain so the bias read settles.
          state_nxt = err ? ST_OUT :
                      (geom.chans == '0 || geom.flt_rows == '0 || geom.flt_cols == '0)
                      ? ST_DRAIN : ST_WALK;
        end
      end
      ST_WALK:  if (walk_done) state_nxt = ST_DRAIN;
      // The drain lets the last read and multiply reach the accumulator and lets the
      // bias read for the new filter become valid before the bias add.
      ST_DRAIN: if (drain_r == 2'd2) state_nxt = ST_BIAS;
      ST_BIAS:  state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
